### hdl/lgss_pkg.sv
// Shared types and constants of the linear gradient span shader.
`timescale 1ns / 1ps
package lgss_pkg;

  localparam int POS_W      = 17;
  localparam int COLOR_W    = 32;
  localparam int COORD_W    = 16;
  localparam int LEN_W      = 7;
  localparam int COEF_W     = 32;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int T_W        = 52;   // Q.17 t before tiling, with headroom for the span walk
  localparam int TT_W       = 18;   // tiled t, 0 .. 2^17
  localparam int NUM_W      = 27;   // 2*num + r of one channel
  localparam int DEN_W      = 19;   // 2*r
  localparam int CH_N       = 4;
  localparam int CH_W       = 8;
  localparam int DIV_ST     = 4;    // two quotient bits per stage

  localparam logic [TT_W-1:0] ONE_T = 18'h20000;

  localparam logic OP_STOP = 1'b0;
  localparam logic OP_SPAN = 1'b1;

  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd4;

  typedef struct packed {
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [COEF_W-1:0] t_offset;
    logic [1:0]        tile_mode;
    logic [4:0]        stop_count;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic [IDX_W-1:0]   stop_index;
    logic [POS_W-1:0]   stop_position;
    logic [COLOR_W-1:0] stop_color;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LEN_W-1:0]   span_length;
  } cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [CH_W-1:0]  q;
  } div_step_t;

  typedef enum logic [2:0] {
    GEN_IDLE,
    GEN_MUL_X,
    GEN_MUL_Y,
    GEN_SUM,
    GEN_RUN
  } gen_state_t;

  // One restoring step for quotient bit sh.
  function automatic div_step_t div_step(input div_step_t cur, input logic [DEN_W-1:0] den,
                                         input int sh);
    div_step_t        res;
    logic [NUM_W-1:0] trial;
    res   = cur;
    trial = NUM_W'(den) << sh;
    if (res.rem >= trial) begin
      res.rem   = res.rem - trial;
      res.q[sh] = 1'b1;
    end
    return res;
  endfunction

endpackage

### hdl/linear_gradient_span_shader_unit.sv
// Top level of the linear gradient span shader: configuration registers and the two parts.
`timescale 1ns / 1ps
// A stop-write item is taken into a two-entry queue and lands in the stop table once it reaches
// the head, the walker is idle and the span pixels ahead of it have passed the stop search.
// A span item of length L first forms the start value of t in the states MUL_X, MUL_Y and
// SUM (two 32x17 multiplies and a sum) and then issues one pixel per cycle while out_stall
// is low; pixels leave a nine-stage pipeline (tile, stop search, stop table read, blend,
// four divide stages, output register) one per cycle while out_stall is low.
// Empty spans and writes past the stop table are accepted and dropped.
module linear_gradient_span_shader_unit #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_SPAN  = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [lgss_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lgss_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    opcode,
  input  logic [lgss_pkg::IDX_W-1:0]              stop_index,
  input  logic [lgss_pkg::POS_W-1:0]              stop_position,
  input  logic [lgss_pkg::COLOR_W-1:0]            stop_color,
  input  logic signed [lgss_pkg::COORD_W-1:0]     pixel_x,
  input  logic signed [lgss_pkg::COORD_W-1:0]     pixel_y,
  input  logic [lgss_pkg::LEN_W-1:0]              span_length,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [lgss_pkg::COLOR_W-1:0]            pixel_color,
  output logic                                    last
);

  lgss_pkg::cfg_t cfg;
  lgss_pkg::cmd_t q_head;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_x     <= '0;
      cfg.coef_y     <= '0;
      cfg.t_offset   <= '0;
      cfg.tile_mode  <= lgss_pkg::TILE_CLAMP;
      cfg.stop_count <= 5'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lgss_pkg::REG_COEF_X:     cfg.coef_x     <= cfg_data;
        lgss_pkg::REG_COEF_Y:     cfg.coef_y     <= cfg_data;
        lgss_pkg::REG_T_OFFSET:   cfg.t_offset   <= cfg_data;
        lgss_pkg::REG_TILE_MODE:  cfg.tile_mode  <= cfg_data[1:0];
        lgss_pkg::REG_STOP_COUNT: cfg.stop_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  lgss_front #(
    .MAX_STOPS (MAX_STOPS),
    .MAX_SPAN  (MAX_SPAN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .stop_index    (stop_index),
    .stop_position (stop_position),
    .stop_color    (stop_color),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .span_length   (span_length),
    .q_head        (q_head),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  lgss_back #(
    .MAX_STOPS (MAX_STOPS),
    .MAX_SPAN  (MAX_SPAN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_head      (q_head),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

### hdl/lgss_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module lgss_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### hdl/lgss_front.sv
// Front part: accepts items, drops the ones with no effect, queues the rest.
`timescale 1ns / 1ps
module lgss_front #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_SPAN  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [lgss_pkg::IDX_W-1:0]           stop_index,
  input  logic [lgss_pkg::POS_W-1:0]           stop_position,
  input  logic [lgss_pkg::COLOR_W-1:0]         stop_color,
  input  logic signed [lgss_pkg::COORD_W-1:0]  pixel_x,
  input  logic signed [lgss_pkg::COORD_W-1:0]  pixel_y,
  input  logic [lgss_pkg::LEN_W-1:0]           span_length,
  output lgss_pkg::cmd_t                       q_head,
  output logic                                 q_valid,
  input  logic                                 q_pop
);

  lgss_pkg::cmd_t             slots [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 count;
  logic                       keep;
  logic                       push;
  lgss_pkg::cmd_t             cmd;
  logic [lgss_pkg::LEN_W-1:0] len_sat;

  always_comb begin
    if (span_length > lgss_pkg::LEN_W'(MAX_SPAN)) begin
      len_sat = lgss_pkg::LEN_W'(MAX_SPAN);
    end else begin
      len_sat = span_length;
    end
    // Empty spans and writes past the table change nothing.
    if (opcode == lgss_pkg::OP_SPAN) begin
      keep = (span_length != '0);
    end else begin
      keep = (32'(stop_index) < MAX_STOPS);
    end
    cmd.opcode        = opcode;
    cmd.stop_index    = stop_index;
    cmd.stop_position = stop_position;
    cmd.stop_color    = stop_color;
    cmd.pixel_x       = pixel_x;
    cmd.pixel_y       = pixel_y;
    cmd.span_length   = len_sat;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

endmodule

### hdl/lgss_back.sv
// Back part: span walker, tiling, stop search, per-channel blend and divide pipeline.
`timescale 1ns / 1ps
module lgss_back #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_SPAN  = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lgss_pkg::cfg_t               cfg,
  input  lgss_pkg::cmd_t               q_head,
  input  logic                         q_valid,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lgss_pkg::COLOR_W-1:0] pixel_color,
  output logic                         last
);

  localparam int IDXW  = $clog2(MAX_STOPS);
  localparam int NW    = $clog2(MAX_STOPS + 1);
  localparam int RAM_W = lgss_pkg::POS_W + lgss_pkg::COLOR_W;
  localparam int T_W   = lgss_pkg::T_W;
  localparam int TT_W  = lgss_pkg::TT_W;
  localparam int LEN_W = lgss_pkg::LEN_W;

  // ---------------- span walker ----------------
  lgss_pkg::gen_state_t   state;
  lgss_pkg::gen_state_t   state_next;
  logic                   gen_pop;
  logic                   gen_write;
  logic                   gen_load;
  logic                   adv;
  logic [LEN_W-1:0]       cnt;
  logic [LEN_W-1:0]       span_len;
  logic [lgss_pkg::COORD_W-1:0] x_reg;
  logic [lgss_pkg::COORD_W-1:0] y_reg;
  logic signed [48:0]     prod_x;
  logic signed [48:0]     prod_y;
  logic signed [T_W-1:0]  acc;
  logic                   cnt_end;

  logic                   s1_v;
  logic signed [T_W-1:0]  s1_t;
  logic                   s1_last;
  logic                   s2_v;
  logic [TT_W-1:0]        s2_tt;
  logic                   s2_last;

  assign adv     = !out_valid || !out_stall;
  assign cnt_end = (cnt == span_len - LEN_W'(1));
  assign q_pop   = gen_pop;

  always_comb begin
    state_next = state;
    unique case (state)
      lgss_pkg::GEN_IDLE: begin
        if (q_valid && q_head.opcode == lgss_pkg::OP_SPAN) begin
          state_next = lgss_pkg::GEN_MUL_X;
        end
      end
      lgss_pkg::GEN_MUL_X: state_next = lgss_pkg::GEN_MUL_Y;
      lgss_pkg::GEN_MUL_Y: state_next = lgss_pkg::GEN_SUM;
      lgss_pkg::GEN_SUM:   state_next = lgss_pkg::GEN_RUN;
      lgss_pkg::GEN_RUN: begin
        if (adv && cnt_end) begin
          state_next = lgss_pkg::GEN_IDLE;
        end
      end
      default: state_next = lgss_pkg::GEN_IDLE;
    endcase
  end

  always_comb begin
    gen_pop   = 1'b0;
    gen_write = 1'b0;
    gen_load  = 1'b0;
    if (state == lgss_pkg::GEN_IDLE && q_valid) begin
      if (q_head.opcode == lgss_pkg::OP_SPAN) begin
        gen_load = 1'b1;
        gen_pop  = 1'b1;
      end else if (!s1_v && !s2_v) begin
        // stop table is read at the search stage; let it drain first
        gen_write = 1'b1;
        gen_pop   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgss_pkg::GEN_IDLE;
    end else begin
      state <= state_next;
    end
    if (gen_load) begin
      x_reg    <= q_head.pixel_x;
      y_reg    <= q_head.pixel_y;
      span_len <= q_head.span_length;
    end
    if (state == lgss_pkg::GEN_MUL_X) begin
      prod_x <= $signed(cfg.coef_x) * $signed({x_reg, 1'b1});
    end
    if (state == lgss_pkg::GEN_MUL_Y) begin
      prod_y <= $signed(cfg.coef_y) * $signed({y_reg, 1'b1});
    end
    if (state == lgss_pkg::GEN_SUM) begin
      acc <= T_W'(prod_x) + T_W'(prod_y) + T_W'($signed({cfg.t_offset, 1'b0}));
      cnt <= '0;
    end else if (state == lgss_pkg::GEN_RUN && adv) begin
      acc <= acc + T_W'($signed({cfg.coef_x, 1'b0}));
      cnt <= cnt + LEN_W'(1);
    end
  end

  // ---------------- stage 1 -> 2: tiling ----------------
  logic [TT_W-1:0] tiled;
  logic [TT_W-1:0] mir;

  always_comb begin
    mir = s1_t[TT_W-1:0];
    if (mir > lgss_pkg::ONE_T) begin
      mir = TT_W'(0) - mir;
    end
    unique case (cfg.tile_mode)
      lgss_pkg::TILE_REPEAT: tiled = {1'b0, s1_t[TT_W-2:0]};
      lgss_pkg::TILE_MIRROR: tiled = mir;
      default: begin
        if (s1_t < 0) begin
          tiled = '0;
        end else if (s1_t > $signed(T_W'(lgss_pkg::ONE_T))) begin
          tiled = lgss_pkg::ONE_T;
        end else begin
          tiled = s1_t[TT_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= (state == lgss_pkg::GEN_RUN);
      s2_v <= s1_v;
    end
    if (adv) begin
      s1_t    <= acc;
      s1_last <= cnt_end;
      s2_tt   <= tiled;
      s2_last <= s1_last;
    end
  end

  // ---------------- stop table and segment search ----------------
  logic [lgss_pkg::POS_W-1:0] posq [MAX_STOPS];
  logic [IDXW+lgss_pkg::IDX_W-1:0] widx;
  logic [IDXW-1:0]  waddr;
  logic [NW-1:0]    n_eff;
  logic [IDXW-1:0]  n_last;
  logic [7:0]       sc8;
  logic [MAX_STOPS-1:0] ge;
  logic [MAX_STOPS-1:0] le;
  logic [IDXW-1:0]  rd_a;
  logic [IDXW-1:0]  rd_b;
  logic             sel_direct;
  logic             found;
  logic [RAM_W-1:0] rdata_a;
  logic [RAM_W-1:0] rdata_b;

  assign widx  = {{IDXW{1'b0}}, q_head.stop_index};
  assign waddr = widx[IDXW-1:0];
  assign sc8   = 8'(cfg.stop_count);

  always_comb begin
    priority if (sc8 < 8'd2) begin
      n_eff = NW'(2);
    end else if (sc8 > 8'(MAX_STOPS)) begin
      n_eff = NW'(MAX_STOPS);
    end else begin
      n_eff = NW'(sc8);
    end
  end
  assign n_last = IDXW'(n_eff - NW'(1));

  always_comb begin
    for (int k = 0; k < MAX_STOPS; k++) begin
      ge[k] = (s2_tt >= {posq[k], 1'b0});
      le[k] = (s2_tt <= {posq[k], 1'b0});
    end
    found = 1'b0;
    rd_a  = n_last;
    // descending so the lowest bracketing segment wins
    for (int k = MAX_STOPS - 2; k >= 0; k--) begin
      if (ge[k] && le[k+1] && (NW'(k + 1) < n_eff)) begin
        found = 1'b1;
        rd_a  = IDXW'(k);
      end
    end
    rd_b       = rd_a + IDXW'(1);
    sel_direct = 1'b0;
    priority if (le[0]) begin
      sel_direct = 1'b1;
      rd_a       = '0;
    end else if (ge[n_last]) begin
      sel_direct = 1'b1;
      rd_a       = n_last;
    end else if (!found) begin
      sel_direct = 1'b1;
      rd_a       = n_last;
    end
    if (sel_direct) begin
      rd_b = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_write) begin
      posq[waddr] <= q_head.stop_position;
    end
  end

  lgss_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_STOPS)
  ) u_stops (
    .clk     (clk),
    .we      (gen_write),
    .waddr   (waddr),
    .wdata   ({q_head.stop_position, q_head.stop_color}),
    .re      (adv),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  logic            s3_v;
  logic            s3_last;
  logic            s3_direct;
  logic [TT_W-1:0] s3_tt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
    if (adv) begin
      s3_last   <= s2_last;
      s3_direct <= sel_direct;
      s3_tt     <= s2_tt;
    end
  end

  // ---------------- blend and divide ----------------
  logic [TT_W-1:0] d_off;
  logic [TT_W-1:0] r_len;
  logic [TT_W-1:0] r_m_d;
  logic [lgss_pkg::NUM_W-1:0] num [lgss_pkg::CH_N];

  assign d_off = s3_tt - {rdata_a[RAM_W-1:lgss_pkg::COLOR_W], 1'b0};
  assign r_len = {rdata_b[RAM_W-1:lgss_pkg::COLOR_W], 1'b0}
               - {rdata_a[RAM_W-1:lgss_pkg::COLOR_W], 1'b0};
  assign r_m_d = r_len - d_off;

  always_comb begin
    for (int c = 0; c < lgss_pkg::CH_N; c++) begin
      num[c] = lgss_pkg::NUM_W'(rdata_a[c*lgss_pkg::CH_W +: lgss_pkg::CH_W]) *
               lgss_pkg::NUM_W'(r_m_d) +
               lgss_pkg::NUM_W'(rdata_b[c*lgss_pkg::CH_W +: lgss_pkg::CH_W]) *
               lgss_pkg::NUM_W'(d_off);
    end
  end

  logic                         dv_v      [lgss_pkg::DIV_ST+1];
  logic                         dv_last   [lgss_pkg::DIV_ST+1];
  logic                         dv_direct [lgss_pkg::DIV_ST+1];
  logic [lgss_pkg::COLOR_W-1:0] dv_col    [lgss_pkg::DIV_ST+1];
  logic [lgss_pkg::DEN_W-1:0]   dv_den    [lgss_pkg::DIV_ST+1];
  lgss_pkg::div_step_t          dv_st     [lgss_pkg::DIV_ST+1][lgss_pkg::CH_N];
  lgss_pkg::div_step_t          dv_nxt    [lgss_pkg::DIV_ST][lgss_pkg::CH_N];

  always_comb begin
    for (int j = 0; j < lgss_pkg::DIV_ST; j++) begin
      for (int c = 0; c < lgss_pkg::CH_N; c++) begin
        dv_nxt[j][c] = lgss_pkg::div_step(dv_st[j][c], dv_den[j], 7 - 2 * j);
        dv_nxt[j][c] = lgss_pkg::div_step(dv_nxt[j][c], dv_den[j], 6 - 2 * j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= lgss_pkg::DIV_ST; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else if (adv) begin
      dv_v[0] <= s3_v;
      for (int j = 1; j <= lgss_pkg::DIV_ST; j++) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
    if (adv) begin
      dv_last[0]   <= s3_last;
      dv_direct[0] <= s3_direct || (r_len == '0);
      dv_col[0]    <= rdata_a[lgss_pkg::COLOR_W-1:0];
      dv_den[0]    <= {r_len, 1'b0};
      for (int c = 0; c < lgss_pkg::CH_N; c++) begin
        dv_st[0][c].rem <= {num[c][lgss_pkg::NUM_W-2:0], 1'b0} + lgss_pkg::NUM_W'(r_len);
        dv_st[0][c].q   <= '0;
      end
      for (int j = 1; j <= lgss_pkg::DIV_ST; j++) begin
        dv_last[j]   <= dv_last[j-1];
        dv_direct[j] <= dv_direct[j-1];
        dv_col[j]    <= dv_col[j-1];
        dv_den[j]    <= dv_den[j-1];
        for (int c = 0; c < lgss_pkg::CH_N; c++) begin
          dv_st[j][c] <= dv_nxt[j-1][c];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic [lgss_pkg::COLOR_W-1:0] blended;

  always_comb begin
    for (int c = 0; c < lgss_pkg::CH_N; c++) begin
      blended[c*lgss_pkg::CH_W +: lgss_pkg::CH_W] = dv_st[lgss_pkg::DIV_ST][c].q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[lgss_pkg::DIV_ST];
    end
    if (adv) begin
      pixel_color <= dv_direct[lgss_pkg::DIV_ST] ? dv_col[lgss_pkg::DIV_ST] : blended;
      last        <= dv_last[lgss_pkg::DIV_ST];
    end
  end

`ifndef SYNTHESIS
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    gen_write |-> (!s1_v && !s2_v))
    else $error("stop write while search stages busy");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    gen_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == lgss_pkg::GEN_RUN) |-> (cnt < span_len))
    else $error("span counter past span length");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_v) |-> (NW'(rd_b) < n_eff))
    else $error("stop read beyond stops in use");
`endif

endmodule
